FILE: design/turr_pkg.sv
// Shared types and constants for the terminal receive-ring register block.
// Holds the transfer payload structs, command codes, register offsets and ring helpers.
// Depends on nothing; every other design file refers to it by scoped names.
package turr_pkg;

	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = PTR_W + 1;
	localparam int PADDR_W    = 3;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_t;

	localparam logic [7:0] OFF_STATUS  = 8'h00;
	localparam logic [7:0] OFF_OUTPUT  = 8'h04;
	localparam logic [7:0] OFF_INPUT   = 8'h08;
	localparam logic [7:0] OFF_COUNT   = 8'h0C;
	localparam logic [7:0] OFF_DROPPED = 8'h14;
	localparam logic [7:0] OFF_MODE    = 8'h18;
	localparam logic [7:0] OFF_ERROUT  = 8'h1C;

	localparam logic [31:0] READ_UNMAPPED = 32'h0000_00FF;

	// Configuration register index, taken from the word address of the port.
	localparam logic CFG_RAW_MODE_SUPPORTED = 1'b0;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  reg_offset;
		logic [31:0] write_data;
		logic [7:0]  host_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        byte_out_valid;
		logic        byte_stream;
		logic [7:0]  byte_out;
		logic        irq_raise;
	} result_t;

	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic cnt_t ring_count(input ptr_t head, input ptr_t tail);
		if (tail >= head) begin
			ring_count = {1'b0, tail} - {1'b0, head};
		end else begin
			ring_count = {1'b0, tail} + CNT_W'(RING_DEPTH) - {1'b0, head};
		end
	endfunction

endpackage

FILE: design/terminal_uart_rx_ring_regs.sv
// Terminal peripheral with a receive ring, bus register decode and a config port.
// Depends on turr_pkg for payload structs, command codes, offsets and ring helpers.
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       turr_pkg::item_t
//  result    out        result_valid / result_stall   turr_pkg::result_t
//  config    in         psel/penable/pwrite, APB      raw_mode_supported at 0x0
//
// One item per cycle unless the result stalls; path: input register, then result register.
// The ring is a 256-entry memory with one registered read port that always holds the
// byte at the current head, so a pop does not wait on it; a write to that slot is forwarded.
// Reset clears pointers, flags and counters; ring contents stay undefined until written.
// A stalled result holds the input register, which in turn stalls the item channel.
module terminal_uart_rx_ring_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  turr_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output turr_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [turr_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic              item_valid_s1;
	turr_pkg::item_t   item_s1;
	logic              result_valid_q;
	turr_pkg::result_t result_q;

	turr_pkg::ptr_t    head_q;
	turr_pkg::ptr_t    tail_q;
	logic              closed_q;
	logic [31:0]       dropped_q;
	logic              granted_q;
	logic              supported_q;

	logic [7:0]        ring [turr_pkg::RING_DEPTH];
	logic [7:0]        ring_rd_q;
	logic              fwd_q;
	logic [7:0]        fwd_byte_q;

	logic              advance;
	logic              empty;
	logic              full;
	logic [7:0]        head_byte;
	turr_pkg::ptr_t    tail_next;
	turr_pkg::ptr_t    head_d;
	logic              ring_we;
	logic              pop;
	logic              drop;
	logic              close_hit;
	logic              mode_we;
	turr_pkg::result_t result_d;

	assign advance    = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = item_valid_s1 && !advance;

	assign empty     = (head_q == tail_q);
	assign tail_next = turr_pkg::ring_next(tail_q);
	assign full      = (tail_next == head_q);
	assign head_byte = fwd_q ? fwd_byte_q : ring_rd_q;

	always_comb begin
		result_d  = '0;
		ring_we   = 1'b0;
		pop       = 1'b0;
		drop      = 1'b0;
		close_hit = 1'b0;
		mode_we   = 1'b0;
		case (item_s1.command)
			turr_pkg::CMD_PUSH: begin
				if (full) begin
					drop = 1'b1;
				end else begin
					ring_we            = 1'b1;
					result_d.irq_raise = 1'b1;
				end
			end
			turr_pkg::CMD_CLOSE: begin
				close_hit          = 1'b1;
				result_d.irq_raise = 1'b1;
			end
			turr_pkg::CMD_READ: begin
				case (item_s1.reg_offset)
					turr_pkg::OFF_STATUS: begin
						result_d.read_data = {29'd0, empty && closed_q, 1'b1, !empty};
					end
					turr_pkg::OFF_INPUT: begin
						if (!empty) begin
							result_d.read_data = {24'd0, head_byte};
							pop                = 1'b1;
						end
					end
					turr_pkg::OFF_COUNT: begin
						result_d.read_data = 32'(turr_pkg::ring_count(head_q, tail_q));
					end
					turr_pkg::OFF_DROPPED: begin
						result_d.read_data = dropped_q;
					end
					turr_pkg::OFF_MODE: begin
						result_d.read_data = {31'd0, granted_q};
					end
					default: begin
						result_d.read_data = turr_pkg::READ_UNMAPPED;
					end
				endcase
			end
			default: begin
				case (item_s1.reg_offset)
					turr_pkg::OFF_OUTPUT: begin
						result_d.byte_out_valid = 1'b1;
						result_d.byte_out       = item_s1.write_data[7:0];
					end
					turr_pkg::OFF_ERROUT: begin
						result_d.byte_out_valid = 1'b1;
						result_d.byte_stream    = 1'b1;
						result_d.byte_out       = item_s1.write_data[7:0];
					end
					turr_pkg::OFF_MODE: begin
						mode_we = 1'b1;
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	// Head as it will stand after this edge; the read port tracks it.
	assign head_d = (advance && pop) ? turr_pkg::ring_next(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			closed_q       <= 1'b0;
			dropped_q      <= '0;
			granted_q      <= 1'b0;
			supported_q    <= 1'b0;
			fwd_q          <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			head_q <= head_d;
			if (advance && ring_we) begin
				tail_q <= tail_next;
			end
			if (advance && drop) begin
				dropped_q <= dropped_q + 32'd1;
			end
			if (advance && close_hit) begin
				closed_q <= 1'b1;
			end
			// The request bit is only ever seen through the grant, so it is folded in here.
			if (advance && mode_we) begin
				granted_q <= item_s1.write_data[0] && supported_q;
			end
			if (psel && penable && pwrite && pready
				&& paddr[2] == turr_pkg::CFG_RAW_MODE_SUPPORTED) begin
				supported_q <= pwdata[0];
			end
			fwd_q <= advance && ring_we && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ring_we) begin
			ring[tail_q] <= item_s1.host_byte;
		end
		ring_rd_q  <= ring[head_d];
		fwd_byte_q <= item_s1.host_byte;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == turr_pkg::CFG_RAW_MODE_SUPPORTED)
		? {31'd0, supported_q} : 32'd0;

endmodule

FILE: design/turr_checker.sv
// Port-level checks for the terminal receive-ring register block, bound to its top level.
// Depends on turr_pkg for the payload struct types.
module turr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input turr_pkg::result_t               result
);

	// A result with no emitted byte carries a clean stream and byte field.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_out_valid |-> !result.byte_stream && result.byte_out == 8'd0)
	else $error("idle byte fields not cleared");

	// Interrupts come only from host pushes and closes, which never return read data
	// or emit a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.irq_raise |-> result.read_data == 32'd0 && !result.byte_out_valid)
	else $error("interrupt mixed with bus access result");

	// A bus write emitting a byte returns no read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_out_valid |-> result.read_data == 32'd0)
	else $error("emitted byte with read data");

	// A stalled result transfer keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("stalled result changed");

endmodule

bind terminal_uart_rx_ring_regs turr_checker u_turr_checker (.*);

FILE: verif/tb_terminal_uart_rx_ring_regs.sv
// Self-checking testbench for terminal_uart_rx_ring_regs: receive ring, bus decode and config.
// Drives item transfers and APB writes, predicts every result and checks it field by field.
// Depends on turr_pkg for payload structs, command codes and register offsets.
module tb_terminal_uart_rx_ring_regs;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [turr_pkg::PADDR_W-1:0] CFG_ADDR =
		{turr_pkg::CFG_RAW_MODE_SUPPORTED, 2'b00};

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	turr_pkg::item_t               item         = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	turr_pkg::result_t             result;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [turr_pkg::PADDR_W-1:0]  paddr        = '0;
	logic [31:0]                   pwdata       = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	// Predicted block state.
	logic [7:0]     ring_bytes [turr_pkg::RING_DEPTH];
	turr_pkg::ptr_t rd_ptr      = '0;
	turr_pkg::ptr_t wr_ptr      = '0;
	logic           closed_seen = 1'b0;
	logic [31:0]    drop_total  = '0;
	logic           mode_req    = 1'b0;
	logic           mode_grant  = 1'b0;
	logic           raw_ok      = 1'b0;

	turr_pkg::result_t expected_results [$];
	int                errors      = 0;
	int                idle_cycles = 0;
	bit                steady      = 1'b0;

	terminal_uart_rx_ring_regs u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	function automatic turr_pkg::result_t predict_terminal(input turr_pkg::item_t it);
		turr_pkg::result_t r;
		turr_pkg::ptr_t    nxt;
		r = '0;
		nxt = turr_pkg::ptr_t'((int'(wr_ptr) + 1) % turr_pkg::RING_DEPTH);
		case (it.command)
			turr_pkg::CMD_PUSH: begin
				// One slot always stays empty, so a full ring drops the byte silently.
				if (nxt == rd_ptr) begin
					drop_total = drop_total + 32'd1;
				end else begin
					ring_bytes[wr_ptr] = it.host_byte;
					wr_ptr = nxt;
					r.irq_raise = 1'b1;
				end
			end
			turr_pkg::CMD_CLOSE: begin
				closed_seen = 1'b1;
				r.irq_raise = 1'b1;
			end
			turr_pkg::CMD_READ: begin
				case (it.reg_offset)
					turr_pkg::OFF_STATUS: begin
						r.read_data = {29'd0, (rd_ptr == wr_ptr) && closed_seen, 1'b1,
							rd_ptr != wr_ptr};
					end
					turr_pkg::OFF_INPUT: begin
						if (rd_ptr != wr_ptr) begin
							r.read_data = {24'd0, ring_bytes[rd_ptr]};
							rd_ptr = turr_pkg::ptr_t'((int'(rd_ptr) + 1) % turr_pkg::RING_DEPTH);
						end
					end
					turr_pkg::OFF_COUNT: begin
						r.read_data = 32'((int'(wr_ptr) + turr_pkg::RING_DEPTH - int'(rd_ptr))
							% turr_pkg::RING_DEPTH);
					end
					turr_pkg::OFF_DROPPED: r.read_data = drop_total;
					turr_pkg::OFF_MODE:    r.read_data = {31'd0, mode_grant};
					default:               r.read_data = turr_pkg::READ_UNMAPPED;
				endcase
			end
			turr_pkg::CMD_WRITE: begin
				if (it.reg_offset == turr_pkg::OFF_OUTPUT) begin
					r.byte_out_valid = 1'b1;
					r.byte_out = it.write_data[7:0];
				end else if (it.reg_offset == turr_pkg::OFF_ERROUT) begin
					r.byte_out_valid = 1'b1;
					r.byte_stream = 1'b1;
					r.byte_out = it.write_data[7:0];
				end else if (it.reg_offset == turr_pkg::OFF_MODE) begin
					mode_req = it.write_data[0];
					mode_grant = mode_req & raw_ok;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic turr_pkg::item_t make_item(input turr_pkg::cmd_t c,
		input logic [7:0] off);
		turr_pkg::item_t it;
		it.command    = c;
		it.reg_offset = off;
		it.write_data = $urandom;
		it.host_byte  = 8'($urandom);
		return it;
	endfunction

	// Called just after the clock rises; returns once the item transfer has taken place.
	task automatic send_item(input turr_pkg::item_t it);
		while (!steady && $urandom_range(0, 99) < 31) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		expected_results.push_back(predict_terminal(it));
	endtask

	task automatic send_write(input logic [7:0] off, input logic [31:0] data);
		turr_pkg::item_t it;
		it = make_item(turr_pkg::CMD_WRITE, off);
		it.write_data = data;
		send_item(it);
	endtask

	task automatic send_push(input logic [7:0] data);
		turr_pkg::item_t it;
		it = make_item(turr_pkg::CMD_PUSH, 8'($urandom));
		it.host_byte = data;
		send_item(it);
	endtask

	// The block must be idle before its configuration changes.
	task automatic write_raw_mode_supported(input logic v);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR;
		pwdata  <= {31'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		raw_ok = v;
	endtask

	task automatic test_directed();
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_COUNT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_DROPPED));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
		send_item(make_item(turr_pkg::CMD_READ, 8'h10));
		send_item(make_item(turr_pkg::CMD_READ, 8'hFF));
		send_push(8'h00);
		send_push(8'hFF);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_COUNT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		send_item(make_item(turr_pkg::CMD_CLOSE, 8'h00));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
		// A second close keeps the flag and raises the interrupt again.
		send_item(make_item(turr_pkg::CMD_CLOSE, 8'hFF));
		send_push(8'hA5);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
		send_write(turr_pkg::OFF_OUTPUT, 32'hFFFF_FF5A);
		send_write(turr_pkg::OFF_ERROUT, 32'h0000_00FF);
		send_write(turr_pkg::OFF_MODE, 32'h0000_0001);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
		send_write(8'h10, 32'hFFFF_FFFF);
		send_write(turr_pkg::OFF_INPUT, 32'hFFFF_FFFF);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
	endtask

	task automatic test_raw_mode();
		write_raw_mode_supported(1'b1);
		send_write(turr_pkg::OFF_MODE, 32'h0000_0001);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
		send_write(turr_pkg::OFF_MODE, 32'hFFFF_FFFE);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
		send_write(turr_pkg::OFF_MODE, 32'h0000_0001);
		write_raw_mode_supported(1'b0);
		// The grant only follows the support bit on the next mode write.
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
		send_write(turr_pkg::OFF_MODE, 32'h0000_0001);
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_MODE));
	endtask

	task automatic test_ring_overflow();
		steady = 1'b1;
		repeat (turr_pkg::RING_DEPTH + 2) send_push(8'($urandom));
		steady = 1'b0;
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_COUNT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_DROPPED));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
		while (rd_ptr != wr_ptr) begin
			if ($urandom_range(0, 15) == 0)
				send_item(make_item(turr_pkg::CMD_READ,
					$urandom_range(0, 1) ? turr_pkg::OFF_STATUS : turr_pkg::OFF_COUNT));
			else
				send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		end
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_INPUT));
		send_item(make_item(turr_pkg::CMD_READ, turr_pkg::OFF_STATUS));
	endtask

	task automatic test_random(input int count, input bit calm_start);
		int             n;
		int             pick;
		turr_pkg::cmd_t c;
		logic [7:0]     off;
		for (n = 0; n < count; n++) begin
			steady = calm_start && (n < count / 2);
			pick = $urandom_range(0, 99);
			off = 8'($urandom);
			if (pick < 40) begin
				c = turr_pkg::CMD_PUSH;
			end else if (pick < 44) begin
				c = turr_pkg::CMD_CLOSE;
			end else if (pick < 80) begin
				c = turr_pkg::CMD_READ;
				case ($urandom_range(0, 9))
					0:       off = turr_pkg::OFF_STATUS;
					1, 2, 3: off = turr_pkg::OFF_INPUT;
					4:       off = turr_pkg::OFF_COUNT;
					5:       off = turr_pkg::OFF_DROPPED;
					6:       off = turr_pkg::OFF_MODE;
					default: ;
				endcase
			end else begin
				c = turr_pkg::CMD_WRITE;
				case ($urandom_range(0, 3))
					0:       off = turr_pkg::OFF_OUTPUT;
					1:       off = turr_pkg::OFF_ERROUT;
					2:       off = turr_pkg::OFF_MODE;
					default: ;
				endcase
			end
			send_item(make_item(c, off));
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin : check_results
		turr_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$error("result transfer with no expected result pending");
			end else begin
				want = expected_results.pop_front();
				if (result.read_data !== want.read_data) begin
					errors++;
					$error("read_data: expected %h, got %h", want.read_data, result.read_data);
				end
				if (result.byte_out_valid !== want.byte_out_valid) begin
					errors++;
					$error("byte_out_valid: expected %b, got %b", want.byte_out_valid,
						result.byte_out_valid);
				end
				if (result.byte_stream !== want.byte_stream) begin
					errors++;
					$error("byte_stream: expected %b, got %b", want.byte_stream,
						result.byte_stream);
				end
				if (result.byte_out !== want.byte_out) begin
					errors++;
					$error("byte_out: expected %h, got %h", want.byte_out, result.byte_out);
				end
				if (result.irq_raise !== want.irq_raise) begin
					errors++;
					$error("irq_raise: expected %b, got %b", want.irq_raise, result.irq_raise);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_raw_mode();
		test_ring_overflow();
		write_raw_mode_supported(1'b1);
		test_random(20, 1'b0);
		write_raw_mode_supported(1'b0);
		test_random(20, 1'b0);
		write_raw_mode_supported(1'b1);
		test_random(30, 1'b1);
		write_raw_mode_supported(1'b0);
		test_random(20, 1'b0);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
